### rtl/cursor_alpha_overlay_defines.svh
// assertion macros for the cursor overlay
`ifndef CURSOR_ALPHA_OVERLAY_DEFINES_SVH
`define CURSOR_ALPHA_OVERLAY_DEFINES_SVH

`ifndef ASSERT_OFF
`define CAO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAO_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAO_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAO_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

### rtl/cao_pkg.sv
`default_nettype none

package cao_pkg;

  localparam int SPRITE_SIDE_DEF = 64;
  localparam int SCREEN_DIM_DEF  = 4096;
  localparam int Q_DEPTH         = 4;
  localparam int OUT_DEPTH       = 8;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 13;

  localparam logic [CFG_IW-1:0] REG_POINTER_X     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POINTER_Y     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_HOT_X         = 3'd2;
  localparam logic [CFG_IW-1:0] REG_HOT_Y         = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SPRITE_HEIGHT = 3'd5;
  localparam logic [CFG_IW-1:0] REG_OVERLAY_EN    = 3'd6;

  localparam logic [6:0]  SIZE_RESET  = 7'd32;
  localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
  localparam logic [31:0] TOP_BYTE    = 32'hFF00_0000;
  localparam int          ALPHA_SHIFT = 24;

  typedef struct packed {
    logic [12:0] pointer_x;
    logic [12:0] pointer_y;
    logic [5:0]  hot_x;
    logic [5:0]  hot_y;
    logic [6:0]  sprite_width;
    logic [6:0]  sprite_height;
    logic        overlay_enable;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    BK_PASS,
    BK_OPAQUE,
    BK_BLEND
  } blend_kind_t;

endpackage

`default_nettype wire

### rtl/cao_ram.sv
`default_nettype none

module cao_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cao_fifo.sv
`default_nettype none

module cao_fifo #(
  parameter int W     = 32,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire logic [W-1:0]   wdata,
  input  wire logic           pop,
  output logic      [W-1:0]   rdata,
  output logic                empty,
  output logic      [CNW-1:0] cnt
);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CNW-1:0] cnt_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_nxt;

  always_comb begin
    wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

endmodule

`default_nettype wire

### rtl/cao_front.sv
`default_nettype none

module cao_front
  import cao_pkg::*;
#(
  parameter int SPRITE_SIDE = SPRITE_SIDE_DEF,
  parameter int SCREEN_DIM  = SCREEN_DIM_DEF,
  localparam int AW  = $clog2(SPRITE_SIDE * SPRITE_SIDE),
  localparam int EW  = AW + 34,
  localparam int QCW = $clog2(Q_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire logic           in_mode,
  input  wire logic [11:0]    in_sprite_addr,
  input  wire logic [31:0]    in_sprite_word,
  input  wire logic [11:0]    in_pix_col,
  input  wire logic [11:0]    in_pix_row,
  input  wire logic [31:0]    in_background,
  input  wire cfg_regs_t      cfg,
  input  wire logic [QCW-1:0] q_cnt,
  output logic                q_push,
  output logic      [EW-1:0]  q_wdata
);

  localparam int DEPTH = SPRITE_SIDE * SPRITE_SIDE;
  localparam int CW    = $clog2(SPRITE_SIDE);
  localparam int SW    = $clog2(SPRITE_SIDE + 1);
  localparam int PW    = CW + SW;

  logic               accept;
  logic signed [14:0] cx;
  logic signed [14:0] cy;
  logic [SW-1:0]      w_cl;
  logic [SW-1:0]      h_cl;
  logic               cov;
  logic               wr_ok;
  logic [PW-1:0]      idx_sum;

  logic          f1_v_r;
  logic          f1_mode_r;
  logic          f1_en_r;
  logic [AW-1:0] f1_addr_r;
  logic [31:0]   f1_data_r;
  logic [CW-1:0] f1_cx_r;
  logic [CW-1:0] f1_cy_r;
  logic [SW-1:0] f1_w_r;
  logic          f2_v_r;
  logic [EW-1:0] f2_entry_r;

  assign in_full = (32'(q_cnt) + 32'(f1_v_r) + 32'(f2_v_r)) >= Q_DEPTH;
  assign accept  = in_push && !in_full;

  // sprite-relative coordinate
  always_comb begin
    cx = $signed({3'b000, in_pix_col}) - $signed({{2{cfg.pointer_x[12]}}, cfg.pointer_x})
         + $signed({9'b0, cfg.hot_x});
    cy = $signed({3'b000, in_pix_row}) - $signed({{2{cfg.pointer_y[12]}}, cfg.pointer_y})
         + $signed({9'b0, cfg.hot_y});
    w_cl = (32'(cfg.sprite_width) > SPRITE_SIDE) ? SW'(SPRITE_SIDE) : SW'(cfg.sprite_width);
    h_cl = (32'(cfg.sprite_height) > SPRITE_SIDE) ? SW'(SPRITE_SIDE) : SW'(cfg.sprite_height);
    cov = cfg.overlay_enable
          && (32'(in_pix_col) < SCREEN_DIM) && (32'(in_pix_row) < SCREEN_DIM)
          && !cx[14] && (cx < $signed(15'(w_cl)))
          && !cy[14] && (cy < $signed(15'(h_cl)));
    wr_ok = 32'(in_sprite_addr) < DEPTH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_mode_r <= in_mode;
      f1_en_r   <= in_mode ? cov : wr_ok;
      f1_addr_r <= AW'(in_sprite_addr);
      f1_data_r <= in_mode ? in_background : in_sprite_word;
      f1_cx_r   <= cx[CW-1:0];
      f1_cy_r   <= cy[CW-1:0];
      f1_w_r    <= w_cl;
    end
  end

  // row-major store index
  assign idx_sum = PW'(f1_cy_r) * PW'(f1_w_r) + PW'(f1_cx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_v_r) begin
      f2_entry_r <= {f1_mode_r, f1_en_r,
                     f1_mode_r ? AW'(idx_sum) : f1_addr_r,
                     f1_data_r};
    end
  end

  assign q_push  = f2_v_r;
  assign q_wdata = f2_entry_r;

endmodule

`default_nettype wire

### rtl/cao_back.sv
`default_nettype none

module cao_back
  import cao_pkg::*;
#(
  parameter int SPRITE_SIDE = SPRITE_SIDE_DEF,
  localparam int AW  = $clog2(SPRITE_SIDE * SPRITE_SIDE),
  localparam int EW  = AW + 34,
  localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire logic [EW-1:0]  q_rdata,
  output logic                q_pop,
  input  wire logic [OCW-1:0] out_cnt,
  output logic                res_push,
  output logic      [32:0]    res_data
);

  localparam int DEPTH = SPRITE_SIDE * SPRITE_SIDE;

  logic          head_mode;
  logic          head_en;
  logic [AW-1:0] head_addr;
  logic [31:0]   head_data;
  logic          credit;
  logic          issue;
  logic          ram_we;
  logic          ram_re;
  logic [31:0]   px;
  logic [7:0]    alpha;
  blend_kind_t   kind;
  logic [15:0]   sum [3];
  logic [16:0]   quo [3];
  logic [31:0]   blended;

  logic          b1_v_r;
  logic          b1_cov_r;
  logic [31:0]   b1_bg_r;
  logic          b2_v_r;
  blend_kind_t   b2_kind_r;
  logic [31:0]   b2_bg_r;
  logic [31:0]   b2_px_r;
  logic [15:0]   b2_sum_r [3];

  assign {head_mode, head_en, head_addr, head_data} = q_rdata;

  // results in flight must always find room in the output queue
  assign credit = (32'(out_cnt) + 32'(b1_v_r) + 32'(b2_v_r)) < OUT_DEPTH;
  assign issue  = !q_empty && (!head_mode || credit);
  assign q_pop  = issue;
  assign ram_we = issue && !head_mode && head_en;
  assign ram_re = issue && head_mode;

  cao_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_addr),
    .wdata (head_data),
    .re    (ram_re),
    .raddr (head_addr),
    .rdata (px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b1_v_r <= ram_re;
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      b1_cov_r <= head_en;
      b1_bg_r  <= head_data;
    end
  end

  always_comb begin
    alpha = px[31:ALPHA_SHIFT];
    if (!b1_cov_r || alpha == '0) begin
      kind = BK_PASS;
    end else if (alpha == ALPHA_FULL) begin
      kind = BK_OPAQUE;
    end else begin
      kind = BK_BLEND;
    end
    for (int c = 0; c < 3; c++) begin
      sum[c] = 16'(px[8*c +: 8]) * 16'(alpha)
               + 16'(b1_bg_r[8*c +: 8]) * 16'(ALPHA_FULL - alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_v_r) begin
      b2_kind_r <= kind;
      b2_bg_r   <= b1_bg_r;
      b2_px_r   <= px;
      for (int c = 0; c < 3; c++) begin
        b2_sum_r[c] <= sum[c];
      end
    end
  end

  // divide by 255: (x + (x >> 8) + 1) >> 8
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo[c] = 17'(b2_sum_r[c]) + 17'(b2_sum_r[c][15:8]) + 17'd1;
    end
    blended = TOP_BYTE | {8'h00, quo[2][15:8], quo[1][15:8], quo[0][15:8]};
    case (b2_kind_r)
      BK_OPAQUE: res_data = {1'b1, b2_px_r | TOP_BYTE};
      BK_BLEND:  res_data = {1'b1, blended};
      default:   res_data = {1'b0, b2_bg_r};
    endcase
  end

  assign res_push = b2_v_r;

endmodule

`default_nettype wire

### rtl/cursor_alpha_overlay.sv
// channel   direction  handshake                 payload
// in_       input      in_push / in_full         mode, sprite_addr, sprite_word,
//                                                pix_col, pix_row, background
// out_      output     out_empty / out_pop       composite_pixel, cursor_hit
// cfg_      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one transaction per clock in both directions when neither side stalls
// path to the output queue head: front registers f1, f2, command queue, store read with b1, b2, result queue
// the rate is set by the single command queue head feeding the sprite store, shared by loads and reads
// front stages feed a four-entry queue; the back end issues reads only with room in
// the eight-entry output queue, so stalls on out_pop back up through the command queue to in_full
// synchronous active-low reset; sprite store contents undefined until loaded
`default_nettype none

`include "cursor_alpha_overlay_defines.svh"

module cursor_alpha_overlay
  import cao_pkg::*;
#(
  parameter int SPRITE_SIDE = SPRITE_SIDE_DEF,
  parameter int SCREEN_DIM  = SCREEN_DIM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              in_mode,
  input  wire logic [11:0]       in_sprite_addr,
  input  wire logic [31:0]       in_sprite_word,
  input  wire logic [11:0]       in_pix_col,
  input  wire logic [11:0]       in_pix_row,
  input  wire logic [31:0]       in_background,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic      [31:0]       out_composite_pixel,
  output logic                   out_cursor_hit,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam int AW  = $clog2(SPRITE_SIDE * SPRITE_SIDE);
  localparam int EW  = AW + 34;
  localparam int QCW = $clog2(Q_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  cfg_regs_t      cfg_r;
  logic           q_push;
  logic [EW-1:0]  q_wdata;
  logic           q_pop;
  logic [EW-1:0]  q_rdata;
  logic           q_empty;
  logic [QCW-1:0] q_cnt;
  logic           res_push;
  logic [32:0]    res_data;
  logic [32:0]    out_rdata;
  logic [OCW-1:0] out_cnt;
  logic           out_pop_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pointer_x      <= '0;
      cfg_r.pointer_y      <= '0;
      cfg_r.hot_x          <= '0;
      cfg_r.hot_y          <= '0;
      cfg_r.sprite_width   <= SIZE_RESET;
      cfg_r.sprite_height  <= SIZE_RESET;
      cfg_r.overlay_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POINTER_X:     cfg_r.pointer_x      <= cfg_data;
        REG_POINTER_Y:     cfg_r.pointer_y      <= cfg_data;
        REG_HOT_X:         cfg_r.hot_x          <= cfg_data[5:0];
        REG_HOT_Y:         cfg_r.hot_y          <= cfg_data[5:0];
        REG_SPRITE_WIDTH:  cfg_r.sprite_width   <= cfg_data[6:0];
        REG_SPRITE_HEIGHT: cfg_r.sprite_height  <= cfg_data[6:0];
        REG_OVERLAY_EN:    cfg_r.overlay_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cao_front #(
    .SPRITE_SIDE (SPRITE_SIDE),
    .SCREEN_DIM  (SCREEN_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_sprite_addr (in_sprite_addr),
    .in_sprite_word (in_sprite_word),
    .in_pix_col     (in_pix_col),
    .in_pix_row     (in_pix_row),
    .in_background  (in_background),
    .cfg            (cfg_r),
    .q_cnt          (q_cnt),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  cao_fifo #(
    .W     (EW),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  cao_back #(
    .SPRITE_SIDE (SPRITE_SIDE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_cnt  (out_cnt),
    .res_push (res_push),
    .res_data (res_data)
  );

  assign out_pop_ok = out_pop && !out_empty;

  cao_fifo #(
    .W     (33),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .pop   (out_pop_ok),
    .rdata (out_rdata),
    .empty (out_empty),
    .cnt   (out_cnt)
  );

  assign out_composite_pixel = out_rdata[31:0];
  assign out_cursor_hit      = out_rdata[32];

  `CAO_ASSERT(a_res_room, clk, rst_n, res_push |-> (32'(out_cnt) < OUT_DEPTH), "result queue overrun")
  `CAO_ASSERT(a_cmd_room, clk, rst_n, q_push |-> (32'(q_cnt) < Q_DEPTH), "command queue overrun")
  `CAO_ASSERT(a_cmd_pop, clk, rst_n, q_pop |-> !q_empty, "command queue underrun")
  `CAO_ASSERT_NORST(a_rst_empty, clk, !rst_n |=> out_empty, "results left after reset")

endmodule

`default_nettype wire

### bench/tb_cursor_alpha_overlay.sv
`timescale 1ns / 100ps

module tb_cursor_alpha_overlay
  import cao_pkg::*;
();

  localparam int ITEMS        = 1150;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400_000;

  localparam logic [12*32-1:0] PROBE_WORDS = {
    32'h7F7F_7F7F, 32'h12AB_CDEF, 32'hC0FF_FFFF, 32'h4080_4020,
    32'h00FF_FFFF, 32'h7F00_FF00, 32'h80FF_00FF, 32'hFE00_0000,
    32'h01FF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h0012_3456
  };

  typedef struct packed {
    logic        mode;
    logic [11:0] addr;
    logic [31:0] word;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [31:0] bg;
  } pix_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        hit;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_push = 1'b0;
  logic              in_full;
  logic              in_mode = 1'b0;
  logic [11:0]       in_sprite_addr = '0;
  logic [31:0]       in_sprite_word = '0;
  logic [11:0]       in_pix_col = '0;
  logic [11:0]       in_pix_row = '0;
  logic [31:0]       in_background = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [31:0]       out_composite_pixel;
  logic              out_cursor_hit;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  cursor_alpha_overlay DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_sprite_addr      (in_sprite_addr),
    .in_sprite_word      (in_sprite_word),
    .in_pix_col          (in_pix_col),
    .in_pix_row          (in_pix_row),
    .in_background       (in_background),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_composite_pixel (out_composite_pixel),
    .out_cursor_hit      (out_cursor_hit),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cursor settings and sprite image as seen by the predictor
  logic signed [12:0] ptr_x = '0;
  logic signed [12:0] ptr_y = '0;
  logic [5:0]         hot_x = '0;
  logic [5:0]         hot_y = '0;
  logic [6:0]         spr_w = SIZE_RESET;
  logic [6:0]         spr_h = SIZE_RESET;
  logic               ovl_en = 1'b0;
  logic [31:0]        sprite_mem [0:4095];

  // entries already loaded by queued transactions
  bit loaded [0:4095];

  pix_item_t   stream_items [$];
  pix_result_t expected_pixels [$];
  pix_item_t   on_bus;
  pix_result_t want;

  int items_queued = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int push_gap = 0;
  int pop_stall = 0;
  int push_gap_pct = 0;
  int pop_stall_pct = 0;

  function automatic int eff_side(logic [6:0] v);
    return (v > SPRITE_SIDE_DEF) ? SPRITE_SIDE_DEF : int'(v);
  endfunction

  // store index under a screen position, -1 where the cursor does not cover it
  function automatic int sprite_index(int x, int y);
    int cx, cy, w, h;
    if (!ovl_en || x >= SCREEN_DIM_DEF || y >= SCREEN_DIM_DEF) return -1;
    w = eff_side(spr_w);
    h = eff_side(spr_h);
    cx = x - (int'(ptr_x) - int'(hot_x));
    cy = y - (int'(ptr_y) - int'(hot_y));
    if (cx < 0 || cx >= w || cy < 0 || cy >= h) return -1;
    return cy * w + cx;
  endfunction

  function automatic pix_result_t overlay_pixel(pix_item_t it);
    pix_result_t r;
    blend_kind_t kind;
    logic [31:0] fg;
    logic [7:0]  a;
    int          idx, f, b, al;
    r.pixel = it.bg;
    r.hit = 1'b0;
    kind = BK_PASS;
    fg = '0;
    a = '0;
    idx = sprite_index(it.sx, it.sy);
    if (idx >= 0) begin
      fg = sprite_mem[idx];
      a = fg[ALPHA_SHIFT +: 8];
      if (a == ALPHA_FULL) kind = BK_OPAQUE;
      else if (a != 8'h00) kind = BK_BLEND;
    end
    case (kind)
      BK_OPAQUE: begin
        r.pixel = fg | TOP_BYTE;
        r.hit = 1'b1;
      end
      BK_BLEND: begin
        r.pixel = TOP_BYTE;
        al = a;
        for (int c = 0; c < 3; c++) begin
          f = fg[8*c +: 8];
          b = it.bg[8*c +: 8];
          r.pixel[8*c +: 8] = 8'((f * al + b * (255 - al)) / 255);
        end
        r.hit = 1'b1;
      end
      BK_PASS: ;
    endcase
    return r;
  endfunction

  function automatic pix_item_t random_item(logic m);
    pix_item_t it;
    it.mode = m;
    it.addr = 12'($urandom_range(0, 4095));
    it.word = $urandom;
    it.sx = 12'($urandom_range(0, 4095));
    it.sy = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0: it.bg = 32'hFFFF_FFFF;
      1: it.bg = 32'h0000_0000;
      default: it.bg = $urandom;
    endcase
    return it;
  endfunction

  function automatic logic [31:0] random_sprite_word();
    logic [31:0] wd;
    wd = $urandom;
    case ($urandom_range(0, 5))
      0: wd[31:24] = 8'h00;
      1, 2: wd[31:24] = ALPHA_FULL;
      3: wd[31:24] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: ;
    endcase
    return wd;
  endfunction

  task automatic add_load(int addr, logic [31:0] word);
    pix_item_t it;
    it = random_item(1'b0);
    it.addr = 12'(addr);
    it.word = word;
    loaded[addr] = 1'b1;
    stream_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_pixel(bit aim, int x, int y);
    pix_item_t it;
    int ox, oy, w, idx;
    it = random_item(1'b1);
    w = eff_side(spr_w);
    ox = int'(ptr_x) - int'(hot_x);
    oy = int'(ptr_y) - int'(hot_y);
    if (aim) begin
      x = ox + int'($urandom_range(0, w + 1)) - 1;
      y = oy + int'($urandom_range(0, eff_side(spr_h) + 1)) - 1;
    end
    if (x >= 0 && x < SCREEN_DIM_DEF) it.sx = 12'(x);
    if (y >= 0 && y < SCREEN_DIM_DEF) it.sy = 12'(y);
    idx = sprite_index(it.sx, it.sy);
    // steer clear of sprite entries that were never loaded
    if (idx >= 0 && !loaded[idx]) it.sx = (ox > 0 || ox + w <= 0) ? 12'd0 : 12'(ox + w);
    stream_items.push_back(it);
    items_queued++;
  endtask

  task automatic fill_sprite();
    for (int i = 0; i < eff_side(spr_w) * eff_side(spr_h); i++)
      add_load(i, random_sprite_word());
  endtask

  task automatic program_cursor(int px, int py, int hx, int hy, int w, int h, int en);
    logic [CFG_DW-1:0] vals [8];
    vals[REG_POINTER_X] = CFG_DW'(px);
    vals[REG_POINTER_Y] = CFG_DW'(py);
    vals[REG_HOT_X] = CFG_DW'(hx);
    vals[REG_HOT_Y] = CFG_DW'(hy);
    vals[REG_SPRITE_WIDTH] = CFG_DW'(w);
    vals[REG_SPRITE_HEIGHT] = CFG_DW'(h);
    vals[REG_OVERLAY_EN] = CFG_DW'(en);
    cfg_valid <= 1'b1;
    for (int r = int'(REG_POINTER_X); r <= int'(REG_OVERLAY_EN); r++) begin
      cfg_index <= CFG_IW'(r);
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (CFG_IW'(r))
        REG_POINTER_X: ptr_x = vals[r];
        REG_POINTER_Y: ptr_y = vals[r];
        REG_HOT_X: hot_x = vals[r][5:0];
        REG_HOT_Y: hot_y = vals[r][5:0];
        REG_SPRITE_WIDTH: spr_w = vals[r][6:0];
        REG_SPRITE_HEIGHT: spr_h = vals[r][6:0];
        REG_OVERLAY_EN: ovl_en = vals[r][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (stream_items.size() != 0 || in_push || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input side driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        if (on_bus.mode) expected_pixels.push_back(overlay_pixel(on_bus));
        else sprite_mem[on_bus.addr] = on_bus.word;
      end
      if (!in_push || !in_full) begin
        if (push_gap > 0) begin
          push_gap--;
          in_push <= 1'b0;
        end else if (push_gap_pct != 0 && $urandom_range(0, 99) < push_gap_pct) begin
          push_gap = $urandom_range(0, 8);
          in_push <= 1'b0;
        end else if (stream_items.size() != 0) begin
          on_bus = stream_items.pop_front();
          in_push <= 1'b1;
          in_mode <= on_bus.mode;
          in_sprite_addr <= on_bus.addr;
          in_sprite_word <= on_bus.word;
          in_pix_col <= on_bus.sx;
          in_pix_row <= on_bus.sy;
          in_background <= on_bus.bg;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result side monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual pixel %h hit %b",
                   $time, out_composite_pixel, out_cursor_hit);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_composite_pixel !== want.pixel) begin
            $display("%0t: composite_pixel expected %h actual %h",
                     $time, want.pixel, out_composite_pixel);
            mismatches++;
          end
          if (out_cursor_hit !== want.hit) begin
            $display("%0t: cursor_hit expected %b actual %b",
                     $time, want.hit, out_cursor_hit);
            mismatches++;
          end
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= 1'b0;
      end else if (pop_stall_pct != 0 && $urandom_range(0, 99) < pop_stall_pct) begin
        pop_stall = $urandom_range(0, 8);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int phase, px, py, hx, hy, w, h, en, n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small known sprite, every cell probed once
    push_gap_pct = 30;
    pop_stall_pct = 30;
    program_cursor(5, 7, 2, 1, 4, 3, 1);
    for (int i = 0; i < 12; i++) add_load(i, PROBE_WORDS[32*i +: 32]);
    for (int i = 0; i < 12; i++) begin
      add_pixel(1'b0, 3 + i % 4, 6 + i / 4);
      case (i % 3)
        0: stream_items[$].bg = 32'hFFFF_FFFF;
        1: stream_items[$].bg = 32'h0000_0000;
        default: ;
      endcase
    end
    add_pixel(1'b0, 0, 0);
    add_pixel(1'b0, 4095, 4095);

    phase = 0;
    while (items_queued < ITEMS) begin
      settle();
      px = int'($urandom_range(0, 4159)) - 64;
      py = int'($urandom_range(0, 4159)) - 64;
      hx = $urandom_range(0, 63);
      hy = $urandom_range(0, 63);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      en = ($urandom_range(0, 5) != 0);
      case (phase % 8)
        1: begin px = 4095; py = 4095; hx = 63; hy = 63; w = 64; h = 2; en = 1; end
        2: begin px = -4096; py = -4096; hx = 0; hy = 0; h = 0; en = 1; end
        3: begin px = 0; py = 0; hx = 0; hy = 0; w = 2; h = 64; en = 1; end
        4: begin w = 127; h = 1; en = 1; end
        5: begin w = 0; en = 1; end
        6: begin w = 1; h = 127; en = 1; end
        7: en = 0;
        default: ;
      endcase
      if (items_queued > ITEMS - 300) begin
        push_gap_pct = 0;
        pop_stall_pct = 0;
      end else begin
        push_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        pop_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      program_cursor(px, py, hx, hy, w, h, en);
      fill_sprite();
      n = $urandom_range(50, 90);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0)
          add_load($urandom_range(0, 4095), random_sprite_word());
        else
          add_pixel($urandom_range(0, 4) != 0, 0, 0);
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && expected_pixels.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
